>>> sv/fat12_cluster_chain_walker_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the FAT12 cluster chain walker
// Concurrent assertion wrappers on clk; compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef FAT12_CLUSTER_CHAIN_WALKER_UNIT_ASSERT_SVH
`define FAT12_CLUSTER_CHAIN_WALKER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked outside reset only.
`define FCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define FCW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define FCW_ASSERT(lbl, prop, msg)
`define FCW_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

>>> sv/fat12w_pkg.sv
// ----------------------------------------------------------------------------
// fat12w_pkg
// Shared types and constants of the FAT12 cluster chain walker.
// ----------------------------------------------------------------------------
`default_nettype none

package fat12w_pkg;

  localparam int unsigned TABLE_BYTES_DEF = 8192;
  localparam int unsigned RUN_LIMIT_DEF   = 64;

  localparam logic [11:0] END_MARK = 12'hFF8;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_START = 2'd1,
    ACT_CONT  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DECODE
  } state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [12:0] byte_address;
    logic [7:0]  byte_value;
    logic [11:0] start_cluster;
  } req_t;

  typedef struct packed {
    logic [11:0] cluster;
    logic        last;
    logic        chain_ended;
    logic        error;
  } rsp_t;

  // Control from the walker to the table store.
  typedef struct packed {
    logic        wr_en;
    logic [12:0] wr_addr;
    logic [7:0]  wr_data;
    logic        rd_en;
    logic [12:0] rd_off;
  } tbl_ctl_t;

endpackage

`default_nettype wire

>>> sv/fat12w_if.sv
// ----------------------------------------------------------------------------
// fat12w_req_if / fat12w_rsp_if
// Valid/ready channels carrying request and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface fat12w_req_if;
  import fat12w_pkg::*;

  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface fat12w_rsp_if;
  import fat12w_pkg::*;

  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> sv/fat12_cluster_chain_walker_unit.sv
// ----------------------------------------------------------------------------
// fat12_cluster_chain_walker_unit
// Follows FAT12 cluster chains through an allocation table held on chip.
//
// req (sink): one word per item. A load word writes byte_value at
// byte_address (addresses at or past TABLE_BYTES are dropped) and gives no
// result. A start word walks from start_cluster; a continue word resumes a
// walk that stopped at the run limit. rsp (source) carries one word per
// emitted cluster; last marks the final word of an item, chain_ended the
// end marker, error a zero start or a continue with nothing pending.
// A load writes the table when it is taken. A walk reads the table for
// each cluster (ST_READ) and then decodes the entry (ST_DECODE), which
// puts the cluster into the result register; a run emits at most
// RUN_LIMIT (64 by default) clusters. One item is in flight at a time.
// A stalled rsp holds the result register and freezes the walk at the
// decode step; req is taken only while no walk runs and the result register
// is free or draining. Reset clears the walk state and the result register;
// the table itself is not cleared and must be loaded before it is walked.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fat12_cluster_chain_walker_unit_assert.svh"

module fat12_cluster_chain_walker_unit #(
  parameter int unsigned TABLE_BYTES = fat12w_pkg::TABLE_BYTES_DEF,
  parameter int unsigned RUN_LIMIT   = fat12w_pkg::RUN_LIMIT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  fat12w_req_if.sink          req,
  fat12w_rsp_if.source        rsp
);
  import fat12w_pkg::*;

  localparam int unsigned CNT_W = $clog2(RUN_LIMIT + 1);

  state_t     state, state_next;
  logic [11:0] cur, cur_next;
  logic [CNT_W-1:0] hop_cnt, hop_cnt_next;
  logic [11:0] resume_cluster, resume_cluster_next;
  logic        walk_pending, walk_pending_next;
  logic        out_valid, out_valid_next;
  rsp_t        out_word, out_word_next;

  tbl_ctl_t    tbl_ctl;
  logic [7:0]  lo_byte;
  logic [7:0]  hi_byte;
  logic [13:0] cur_x3;
  logic [11:0] entry;
  logic        out_free;
  logic        in_ready;
  logic        in_take;
  logic        run_done;

  fat12w_table #(
    .TABLE_BYTES (TABLE_BYTES)
  ) u_table (
    .clk     (clk),
    .ctl     (tbl_ctl),
    .lo_byte (lo_byte),
    .hi_byte (hi_byte)
  );

  assign out_free = !out_valid || rsp.ready;
  assign in_ready = (state == ST_IDLE) && out_free;
  assign in_take  = req.valid && in_ready;

  assign req.ready   = in_ready;
  assign rsp.valid   = out_valid;
  assign rsp.payload = out_word;

  // Entry offset is floor(cluster * 1.5).
  assign cur_x3 = {2'b00, cur} + {1'b0, cur, 1'b0};
  assign entry  = cur[0] ? {hi_byte, lo_byte[7:4]} : {hi_byte[3:0], lo_byte};
  assign run_done = (32'(hop_cnt) + 32'd1) >= RUN_LIMIT;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      hop_cnt        <= '0;
      resume_cluster <= '0;
      walk_pending   <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      hop_cnt        <= hop_cnt_next;
      resume_cluster <= resume_cluster_next;
      walk_pending   <= walk_pending_next;
      out_valid      <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    out_word <= out_word_next;
  end

  // Table writes happen only in idle and reads only while walking, so an
  // access never overlaps a write to the same byte.
  always_comb begin
    state_next          = state;
    cur_next            = cur;
    hop_cnt_next        = hop_cnt;
    resume_cluster_next = resume_cluster;
    walk_pending_next   = walk_pending;
    out_word_next       = out_word;
    out_valid_next      = out_valid && !rsp.ready;

    tbl_ctl         = '0;
    tbl_ctl.wr_addr = req.payload.byte_address;
    tbl_ctl.wr_data = req.payload.byte_value;
    tbl_ctl.rd_off  = cur_x3[13:1];

    unique case (state)
      ST_IDLE: begin
        if (in_take) begin
          case (req.payload.action)
            ACT_LOAD: begin
              tbl_ctl.wr_en = 32'(req.payload.byte_address) < TABLE_BYTES;
            end
            ACT_START: begin
              if (req.payload.start_cluster == 12'd0) begin
                walk_pending_next   = 1'b0;
                resume_cluster_next = '0;
                out_valid_next      = 1'b1;
                out_word_next       = '{cluster: '0, last: 1'b1,
                                        chain_ended: 1'b0, error: 1'b1};
              end else begin
                cur_next     = req.payload.start_cluster;
                hop_cnt_next = '0;
                state_next   = ST_READ;
              end
            end
            ACT_CONT: begin
              if (walk_pending) begin
                cur_next     = resume_cluster;
                hop_cnt_next = '0;
                state_next   = ST_READ;
              end else begin
                out_valid_next = 1'b1;
                out_word_next  = '{cluster: '0, last: 1'b1,
                                   chain_ended: 1'b0, error: 1'b1};
              end
            end
            default: begin
              // drop unused action code
            end
          endcase
        end
      end
      ST_READ: begin
        tbl_ctl.rd_en = 1'b1;
        state_next    = ST_DECODE;
      end
      ST_DECODE: begin
        // Hold here on a stalled result; read data stays registered.
        if (out_free) begin
          out_valid_next = 1'b1;
          out_word_next  = '{cluster: cur, last: 1'b0,
                             chain_ended: 1'b0, error: 1'b0};
          if (entry >= END_MARK) begin
            out_word_next.last        = 1'b1;
            out_word_next.chain_ended = 1'b1;
            walk_pending_next         = 1'b0;
            resume_cluster_next       = '0;
            state_next                = ST_IDLE;
          end else if (run_done) begin
            out_word_next.last  = 1'b1;
            walk_pending_next   = 1'b1;
            resume_cluster_next = entry;
            state_next          = ST_IDLE;
          end else begin
            cur_next     = entry;
            hop_cnt_next = hop_cnt + CNT_W'(1);
            state_next   = ST_READ;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `FCW_ASSERT(a_no_rd_wr_overlap, tbl_ctl.rd_en |-> !tbl_ctl.wr_en, "table read and write collide")
  `FCW_ASSERT(a_end_is_last, (rsp.valid && rsp.payload.chain_ended) |-> rsp.payload.last, "chain end without last")
  `FCW_ASSERT(a_error_word, (rsp.valid && rsp.payload.error) |-> (rsp.payload.last && !rsp.payload.chain_ended && rsp.payload.cluster == 12'd0), "malformed error word")
  `FCW_ASSERT(a_hop_bound, 32'(hop_cnt) < RUN_LIMIT, "hop count past run limit")
  `FCW_ASSERT_ALWAYS(a_reset_clears, rst |=> (!out_valid && state == ST_IDLE && !walk_pending), "reset did not clear walk state")

endmodule

`default_nettype wire

>>> sv/fat12w_table.sv
// ----------------------------------------------------------------------------
// fat12w_table
// Allocation table store, split into even and odd byte banks so that both
// bytes of a packed 12-bit entry come out of one registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module fat12w_table #(
  parameter int unsigned TABLE_BYTES = fat12w_pkg::TABLE_BYTES_DEF
) (
  input  logic                 clk,
  input  fat12w_pkg::tbl_ctl_t ctl,
  output logic [7:0]           lo_byte,
  output logic [7:0]           hi_byte
);
  import fat12w_pkg::*;

  localparam int unsigned BANK_DEPTH = (TABLE_BYTES + 1) / 2;
  localparam int unsigned BAW        = $clog2(BANK_DEPTH);

  logic [7:0]     bank_even [BANK_DEPTH];
  logic [7:0]     bank_odd  [BANK_DEPTH];
  logic [7:0]     even_q;
  logic [7:0]     odd_q;
  logic           rd_swap;
  logic [BAW-1:0] wr_idx;
  logic [BAW-1:0] even_idx;
  logic [BAW-1:0] odd_idx;

  assign wr_idx = BAW'(ctl.wr_addr[12:1]);
  // Odd offset: first byte is in the odd bank, second in the next even row.
  assign even_idx = BAW'(ctl.rd_off[12:1] + 12'(ctl.rd_off[0]));
  assign odd_idx  = BAW'(ctl.rd_off[12:1]);

  always_ff @(posedge clk) begin
    if (ctl.wr_en && !ctl.wr_addr[0]) begin
      bank_even[wr_idx] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      even_q <= bank_even[even_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en && ctl.wr_addr[0]) begin
      bank_odd[wr_idx] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      odd_q   <= bank_odd[odd_idx];
      rd_swap <= ctl.rd_off[0];
    end
  end

  assign lo_byte = rd_swap ? odd_q : even_q;
  assign hi_byte = rd_swap ? even_q : odd_q;

endmodule

`default_nettype wire

>>> test/fat12_chain_watch.sv
// ----------------------------------------------------------------------------
// fat12_chain_watch
// Watches the request and result channels of the cluster chain walker. It
// keeps its own copy of the allocation table and of the pending walk, works
// out the cluster words that each accepted request must produce, and
// compares every accepted result word with the oldest one still owed.
// ----------------------------------------------------------------------------
`default_nettype none

module fat12_chain_watch #(
  parameter int unsigned TABLE_BYTES = fat12w_pkg::TABLE_BYTES_DEF,
  parameter int unsigned RUN_LIMIT   = fat12w_pkg::RUN_LIMIT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic             req_ready,
  input  fat12w_pkg::req_t req_word,
  input  logic             rsp_valid,
  input  logic             rsp_ready,
  input  fat12w_pkg::rsp_t rsp_word,
  output int unsigned      mismatches,
  output int unsigned      backlog,
  output int unsigned      clusters_seen,
  output int unsigned      chain_ends,
  output int unsigned      limit_stops,
  output int unsigned      error_words
);
  timeunit 1ns;
  timeprecision 1ps;
  import fat12w_pkg::*;

  logic [7:0]  fat_bytes [TABLE_BYTES];
  logic [11:0] resume_at;
  logic        walk_open;
  rsp_t        owed_clusters [$];

  function automatic logic [11:0] fat_entry(logic [11:0] c);
    int unsigned off;
    logic [7:0]  b0;
    logic [7:0]  b1;
    off = (int'(c) * 3) >> 1;
    b0 = (off < TABLE_BYTES) ? fat_bytes[off] : 8'h00;
    b1 = (off + 1 < TABLE_BYTES) ? fat_bytes[off + 1] : 8'h00;
    // odd entries take the high nibble of b0 and all of b1, even ones all of b0 and the low nibble of b1
    return c[0] ? {b1, b0[7:4]} : {b1[3:0], b0};
  endfunction

  function automatic rsp_t cluster_word(logic [11:0] c, logic fin, logic ended, logic err);
    return rsp_t'({c, fin, ended, err});
  endfunction

  function automatic void follow_chain(logic [11:0] first);
    logic [11:0] cur;
    logic [11:0] nxt;
    int unsigned n;
    bit          done;
    cur  = first;
    n    = 0;
    done = 1'b0;
    while (!done) begin
      nxt = fat_entry(cur);
      if (nxt >= END_MARK) begin
        owed_clusters.push_back(cluster_word(cur, 1'b1, 1'b1, 1'b0));
        walk_open = 1'b0;
        resume_at = '0;
        done      = 1'b1;
      end else if (n + 1 >= RUN_LIMIT) begin
        // park the walk on the next cluster
        owed_clusters.push_back(cluster_word(cur, 1'b1, 1'b0, 1'b0));
        walk_open = 1'b1;
        resume_at = nxt;
        done      = 1'b1;
      end else begin
        owed_clusters.push_back(cluster_word(cur, 1'b0, 1'b0, 1'b0));
        n++;
        cur = nxt;
      end
    end
  endfunction

  function automatic void predict(req_t w);
    case (action_t'(w.action))
      ACT_LOAD: begin
        if (w.byte_address < TABLE_BYTES) fat_bytes[w.byte_address] = w.byte_value;
      end
      ACT_START: begin
        if (w.start_cluster == '0) begin
          walk_open = 1'b0;
          resume_at = '0;
          owed_clusters.push_back(cluster_word('0, 1'b1, 1'b0, 1'b1));
        end else begin
          follow_chain(w.start_cluster);
        end
      end
      ACT_CONT: begin
        if (!walk_open) owed_clusters.push_back(cluster_word('0, 1'b1, 1'b0, 1'b1));
        else follow_chain(resume_at);
      end
      default: ;  // ACT_NONE: drop
    endcase
  endfunction

  function automatic bit field_ok(string name, logic [11:0] want, logic [11:0] got);
    if (got !== want) $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    return got === want;
  endfunction

  function automatic void compare(rsp_t got);
    rsp_t want;
    bit   ok;
    clusters_seen++;
    if (got.chain_ended === 1'b1) chain_ends++;
    if (got.error === 1'b1) error_words++;
    if (got.last === 1'b1 && got.chain_ended === 1'b0 && got.error === 1'b0) limit_stops++;
    if (owed_clusters.size() == 0) begin
      $error("cluster word 0x%0h arrived with none owed", got.cluster);
      mismatches++;
      return;
    end
    want = owed_clusters.pop_front();
    ok = field_ok("cluster", want.cluster, got.cluster);
    ok &= field_ok("last", 12'(want.last), 12'(got.last));
    ok &= field_ok("chain_ended", 12'(want.chain_ended), 12'(got.chain_ended));
    ok &= field_ok("error", 12'(want.error), 12'(got.error));
    if (!ok) mismatches++;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      owed_clusters.delete();
      walk_open = 1'b0;
      resume_at = '0;
    end else begin
      if (rsp_valid && rsp_ready) compare(rsp_word);
      if (req_valid && req_ready) predict(req_word);
    end
    backlog = owed_clusters.size();
  end

endmodule

`default_nettype wire

>>> test/fat12_cluster_chain_walker_unit_test.sv
// ----------------------------------------------------------------------------
// fat12_cluster_chain_walker_unit_test
// Drives table loads and chain walks into the walker. Every walk is laid out
// on written table bytes first, with chains that end, loop, run past the run
// limit and pass through entries 0 and 1; the paced phases idle the sender,
// stall the receiver and hold results off long enough to back up requests.
// ----------------------------------------------------------------------------
`default_nettype none

module fat12_cluster_chain_walker_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import fat12w_pkg::*;

  localparam int unsigned TABLE_BYTES = TABLE_BYTES_DEF;
  localparam int unsigned RUN_LIMIT   = RUN_LIMIT_DEF;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASE_WORDS = 18;

  typedef enum int unsigned {
    PACE_STEADY,
    PACE_SRC_IDLE,
    PACE_SNK_STALL,
    PACE_BOTH
  } pace_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fat12w_req_if req_ch ();
  fat12w_rsp_if rsp_ch ();

  int unsigned mismatches;
  int unsigned backlog;
  int unsigned clusters_seen;
  int unsigned chain_ends;
  int unsigned limit_stops;
  int unsigned error_words;

  pace_t       pace          = PACE_STEADY;
  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;
  bit          held_off      = 1'b0;

  // Stimulus-side image of the table: keeps every walk on written bytes.
  logic [7:0]  table_img [TABLE_BYTES];
  bit          table_set [TABLE_BYTES];
  logic [11:0] laid [$];
  bit          plan_pending = 1'b0;
  logic [11:0] plan_resume  = '0;
  int unsigned loads_sent   = 0;
  int unsigned walks_sent   = 0;
  int unsigned words_sent   = 0;

  fat12_cluster_chain_walker_unit #(
    .TABLE_BYTES (TABLE_BYTES),
    .RUN_LIMIT   (RUN_LIMIT)
  ) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  fat12_chain_watch #(
    .TABLE_BYTES (TABLE_BYTES),
    .RUN_LIMIT   (RUN_LIMIT)
  ) u_watch (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_ch.valid),
    .req_ready     (req_ch.ready),
    .req_word      (req_ch.payload),
    .rsp_valid     (rsp_ch.valid),
    .rsp_ready     (rsp_ch.ready),
    .rsp_word      (rsp_ch.payload),
    .mismatches    (mismatches),
    .backlog       (backlog),
    .clusters_seen (clusters_seen),
    .chain_ends    (chain_ends),
    .limit_stops   (limit_stops),
    .error_words   (error_words)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("timeout with %0d cluster words still owed", backlog);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic set_pace(pace_t p);
    pace = p;
    case (p)
      PACE_STEADY:    begin src_idle_pct = 0;  snk_stall_pct = 0;  end
      PACE_SRC_IDLE:  begin src_idle_pct = 53; snk_stall_pct = 0;  end
      PACE_SNK_STALL: begin src_idle_pct = 0;  snk_stall_pct = 53; end
      PACE_BOTH:      begin src_idle_pct = 18; snk_stall_pct = 18; end
    endcase
  endtask

  task automatic send_word(action_t a, logic [12:0] addr, logic [7:0] val, logic [11:0] sc);
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.payload <= req_t'({a, addr, val, sc});
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    words_sent++;
  endtask

  function automatic logic [11:0] img_entry(logic [11:0] c);
    int unsigned off;
    off = (int'(c) * 3) >> 1;
    return c[0] ? {table_img[off + 1], table_img[off][7:4]}
                : {table_img[off + 1][3:0], table_img[off]};
  endfunction

  task automatic put_byte(logic [12:0] addr, logic [7:0] val);
    table_img[addr] = val;
    table_set[addr] = 1'b1;
    loads_sent++;
    send_word(ACT_LOAD, addr, val, 12'($urandom));
  endtask

  // Write whichever bytes of this entry are still blank; bytes already
  // written stay, since an earlier cluster of the same walk may rely on them.
  // New entries mostly end the chain or jump into one already laid, so that
  // laying a walk costs only a few loads.
  task automatic fill_entry(logic [11:0] c);
    int unsigned off;
    int unsigned r;
    logic [11:0] v;
    logic [3:0]  spare;
    off = (int'(c) * 3) >> 1;
    if (table_set[off] && table_set[off + 1]) return;
    r     = $urandom_range(99);
    spare = 4'($urandom);
    if (r < 25) v = END_MARK + 12'($urandom_range(7));
    else if (r < 55 && laid.size() > 0) v = laid[$urandom_range(laid.size() - 1)];
    else if (r < 60) v = 12'($urandom_range(1));
    else v = 12'($urandom);
    if (!table_set[off]) put_byte(13'(off), c[0] ? {v[3:0], spare} : v[7:0]);
    if (!table_set[off + 1]) put_byte(13'(off + 1), c[0] ? v[11:4] : {spare, v[11:8]});
    laid.push_back(c);
  endtask

  task automatic lay_chain(logic [11:0] first);
    logic [11:0] cur;
    logic [11:0] nxt;
    int unsigned n;
    bit          done;
    cur  = first;
    n    = 0;
    done = 1'b0;
    while (!done) begin
      fill_entry(cur);
      nxt = img_entry(cur);
      if (nxt >= END_MARK) begin
        plan_pending = 1'b0;
        done         = 1'b1;
      end else if (n + 1 >= RUN_LIMIT) begin
        plan_pending = 1'b1;
        plan_resume  = nxt;
        done         = 1'b1;
      end else begin
        n++;
        cur = nxt;
      end
    end
  endtask

  task automatic walk_from(logic [11:0] c);
    if (c == '0) plan_pending = 1'b0;
    else lay_chain(c);
    walks_sent++;
    send_word(ACT_START, 13'($urandom), 8'($urandom), c);
  endtask

  task automatic resume_walk();
    if (plan_pending) lay_chain(plan_resume);
    walks_sent++;
    send_word(ACT_CONT, 13'($urandom), 8'($urandom), 12'($urandom));
  endtask

  // Each phase runs until it has sent PHASE_WORDS words, loads included.
  task automatic random_phase(pace_t p);
    int unsigned first;
    int unsigned r;
    set_pace(p);
    first = words_sent;
    while (words_sent - first < PHASE_WORDS) begin
      r = $urandom_range(99);
      if (r < 5) begin
        send_word(ACT_NONE, 13'($urandom), 8'($urandom), 12'($urandom));
      end else begin
        if (plan_pending && r < 35) resume_walk();
        else if (r < 38) resume_walk();
        else if (r < 41) walk_from('0);
        else if (r < 55) put_byte(13'($urandom), 8'($urandom));
        else if (r < 70 && laid.size() > 0) walk_from(laid[$urandom_range(laid.size() - 1)]);
        else walk_from(12'($urandom_range(4095, 1)));
      end
    end
  endtask

  // Result side: random stalls, plus one long hold-off while a walk is
  // emitting so that the next request backs up behind it.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        rsp_ch.ready <= 1'b0;
      end else if (pace == PACE_SNK_STALL && !held_off && rsp_ch.valid === 1'b1) begin
        held_off = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  initial begin
    req_ch.valid   <= 1'b0;
    req_ch.payload <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    set_pace(PACE_STEADY);

    // errors and ignored words straight out of reset
    resume_walk();
    walk_from('0);
    send_word(ACT_NONE, 13'h1FFF, 8'hFF, 12'hFFF);
    put_byte(13'h1FFF, 8'hFF);
    put_byte(13'h0000, 8'h00);

    // top cluster ends at once
    put_byte(13'd6142, 8'hF0);
    put_byte(13'd6143, 8'hFF);
    walk_from(12'hFFF);

    // chain 5 -> 0 -> 1 -> end marker
    put_byte(13'd7, 8'h00);
    put_byte(13'd8, 8'h00);
    put_byte(13'd0, 8'h01);
    put_byte(13'd1, 8'h80);
    put_byte(13'd2, 8'hFF);
    walk_from(12'd5);

    // loop 2 <-> 3: hits the run limit every time
    put_byte(13'd3, 8'h03);
    put_byte(13'd4, 8'h20);
    put_byte(13'd5, 8'h00);
    walk_from(12'd2);
    resume_walk();
    walk_from('0);
    resume_walk();
    walk_from(12'd2);
    walk_from(12'hFFF);
    resume_walk();

    random_phase(PACE_SRC_IDLE);
    random_phase(PACE_SNK_STALL);
    random_phase(PACE_BOTH);
    random_phase(PACE_STEADY);

    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d words: %0d table loads, %0d walk/continue requests (%0d laid clusters).",
             words_sent, loads_sent, walks_sent, laid.size());
    $display("Checked %0d cluster words: %0d chain ends, %0d run-limit stops, %0d errors%s.",
             clusters_seen, chain_ends, limit_stops, error_words,
             held_off ? ", with a long result hold-off" : "");
    if (mismatches == 0 && backlog == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
+incdir+sv
sv/fat12w_pkg.sv
sv/fat12w_if.sv
sv/fat12w_table.sv
sv/fat12_cluster_chain_walker_unit.sv
test/fat12_chain_watch.sv
test/fat12_cluster_chain_walker_unit_test.sv
